FILE: src/nepr_pkg.sv
// Shared types, constants and color tables for the nearest EGA palette remap unit.
`default_nettype none

package nepr_pkg;

  // Number of reference colors, one cell each.
  localparam int unsigned NumRefs = 16;
  localparam int unsigned RefIdxW = $clog2(NumRefs);

  // Scaled distance that a reference has to beat; the best starts here.
  localparam int unsigned DistW = 7;
  localparam logic [DistW-1:0] StartBest = 7'h40;

  // Width of an L1 distance over three 8-bit components (at most 765).
  localparam int unsigned SumW = 10;

  // Divide-by-three through a reciprocal: q = (d * 683) >> 11, exact for d < 766.
  localparam int unsigned RecipMul   = 683;
  localparam int unsigned RecipShift = 11;
  localparam int unsigned ProdW      = SumW + 10;

  localparam int unsigned AttrW = 5;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Word handed from one cell to the next.
  typedef struct packed {
    logic               valid;
    rgb_t               color;
    logic [DistW-1:0]   best_dist;
    logic [RefIdxW-1:0] best_ref;
  } stage_t;

  // Reference colors that the input is matched against.
  function automatic rgb_t ref_rgb(input logic [RefIdxW-1:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd0,   8'd0,   8'd170};
      4'd2:    c = '{8'd0,   8'd170, 8'd0};
      4'd3:    c = '{8'd0,   8'd170, 8'd170};
      4'd4:    c = '{8'd170, 8'd0,   8'd0};
      4'd5:    c = '{8'd170, 8'd0,   8'd170};
      4'd6:    c = '{8'd170, 8'd170, 8'd0};
      4'd7:    c = '{8'd170, 8'd170, 8'd170};
      4'd8:    c = '{8'd85,  8'd85,  8'd85};
      4'd9:    c = '{8'd85,  8'd85,  8'd255};
      4'd10:   c = '{8'd85,  8'd255, 8'd85};
      4'd11:   c = '{8'd85,  8'd255, 8'd255};
      4'd12:   c = '{8'd255, 8'd85,  8'd85};
      4'd13:   c = '{8'd255, 8'd85,  8'd255};
      4'd14:   c = '{8'd255, 8'd255, 8'd85};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  // Attribute register value for each reference; light green folds onto green.
  function automatic logic [AttrW-1:0] attr_of_ref(input logic [RefIdxW-1:0] idx);
    logic [AttrW-1:0] a;
    unique case (idx)
      4'd0:    a = 5'h00;
      4'd1:    a = 5'h01;
      4'd2:    a = 5'h02;
      4'd3:    a = 5'h03;
      4'd4:    a = 5'h04;
      4'd5:    a = 5'h05;
      4'd6:    a = 5'h06;
      4'd7:    a = 5'h07;
      4'd8:    a = 5'h10;
      4'd9:    a = 5'h11;
      4'd10:   a = 5'h02;
      4'd11:   a = 5'h13;
      4'd12:   a = 5'h14;
      4'd13:   a = 5'h15;
      4'd14:   a = 5'h16;
      default: a = 5'h17;
    endcase
    return a;
  endfunction

  // Default 16-color display palette; index 6 shows brown.
  function automatic rgb_t shown_rgb(input logic [3:0] disp);
    rgb_t c;
    unique case (disp)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd0,   8'd0,   8'd170};
      4'd2:    c = '{8'd0,   8'd170, 8'd0};
      4'd3:    c = '{8'd0,   8'd170, 8'd170};
      4'd4:    c = '{8'd170, 8'd0,   8'd0};
      4'd5:    c = '{8'd170, 8'd0,   8'd170};
      4'd6:    c = '{8'd170, 8'd85,  8'd0};
      4'd7:    c = '{8'd170, 8'd170, 8'd170};
      4'd8:    c = '{8'd85,  8'd85,  8'd85};
      4'd9:    c = '{8'd85,  8'd85,  8'd255};
      4'd10:   c = '{8'd85,  8'd255, 8'd85};
      4'd11:   c = '{8'd85,  8'd255, 8'd255};
      4'd12:   c = '{8'd255, 8'd85,  8'd85};
      4'd13:   c = '{8'd255, 8'd85,  8'd255};
      4'd14:   c = '{8'd255, 8'd255, 8'd85};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/nepr_cell.sv
// One matching cell: compares the passing color against one reference color.
`default_nettype none

module nepr_cell #(
  parameter int unsigned RefIdx = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nepr_pkg::stage_t stage_i,
  output nepr_pkg::stage_t     stage_o
);

  localparam logic [nepr_pkg::RefIdxW-1:0] Idx = nepr_pkg::RefIdxW'(RefIdx);
  localparam nepr_pkg::rgb_t Ref = nepr_pkg::ref_rgb(Idx);

  logic [7:0]                   diff_r, diff_g, diff_b;
  logic [nepr_pkg::SumW-1:0]    l1_sum;
  logic [nepr_pkg::ProdW-1:0]   prod;
  logic [8:0]                   scaled;
  logic                         closer;
  nepr_pkg::stage_t             stage_d;
  logic                         valid_q;
  nepr_pkg::rgb_t               color_q;
  logic [nepr_pkg::DistW-1:0]   best_dist_q;
  logic [nepr_pkg::RefIdxW-1:0] best_ref_q;

  // Absolute component differences and their L1 sum.
  assign diff_r = (stage_i.color.red >= Ref.red) ? stage_i.color.red - Ref.red
                                                 : Ref.red - stage_i.color.red;
  assign diff_g = (stage_i.color.green >= Ref.green) ? stage_i.color.green - Ref.green
                                                     : Ref.green - stage_i.color.green;
  assign diff_b = (stage_i.color.blue >= Ref.blue) ? stage_i.color.blue - Ref.blue
                                                   : Ref.blue - stage_i.color.blue;
  assign l1_sum = nepr_pkg::SumW'(diff_r) + nepr_pkg::SumW'(diff_g)
                + nepr_pkg::SumW'(diff_b);

  // Truncating divide by three through the reciprocal constant.
  assign prod   = nepr_pkg::ProdW'(l1_sum) * nepr_pkg::ProdW'(nepr_pkg::RecipMul);
  assign scaled = prod[nepr_pkg::RecipShift +: 9];

  // Only a strictly smaller distance takes over, so the earlier reference wins ties.
  assign closer = scaled < {2'b00, stage_i.best_dist};

  always_comb begin
    stage_d = stage_i;
    if (closer) begin
      stage_d.best_dist = scaled[nepr_pkg::DistW-1:0];
      stage_d.best_ref  = Idx;
    end
  end

  // Valid bit of the word held by this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  // Payload of the word held by this cell.
  always_ff @(posedge clk_i) begin
    color_q     <= stage_d.color;
    best_dist_q <= stage_d.best_dist;
    best_ref_q  <= stage_d.best_ref;
  end

  assign stage_o = {valid_q, color_q, best_dist_q, best_ref_q};

endmodule

`default_nettype wire

FILE: src/nepr_out.sv
// Result stage: maps the winning reference to its attribute value and shown color.
`default_nettype none

module nepr_out (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nepr_pkg::stage_t              stage_i,
  output logic                               done_o,
  output logic [nepr_pkg::AttrW-1:0]         atc_value_o,
  output nepr_pkg::rgb_t                     show_o
);

  logic [nepr_pkg::AttrW-1:0] attr;
  logic [3:0]                 disp;
  logic                       done_q;
  logic [nepr_pkg::AttrW-1:0] attr_q;
  nepr_pkg::rgb_t             show_q;

  // Display index takes bits 2:0 of the attribute and moves bit 4 down to bit 3.
  assign attr = nepr_pkg::attr_of_ref(stage_i.best_ref);
  assign disp = {attr[4], attr[2:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    attr_q <= attr;
    show_q <= nepr_pkg::shown_rgb(disp);
  end

  assign done_o      = done_q;
  assign atc_value_o = attr_q;
  assign show_o      = show_q;

endmodule

`default_nettype wire

FILE: src/nearest_ega_palette_remap_unit.sv
// Top level of the nearest EGA palette remap unit: a chain of matching cells and a result stage.
`default_nettype none

// Maps an 8-bit RGB color to the nearest of 16 EGA reference colors by L1
// distance divided by three, and returns the attribute register value with the
// default palette color that it shows. A color is accepted on every cycle that
// start_i is high; busy_o is always low. Each color walks through a row of 16
// cells, one reference per cell and one cell per cycle, followed by one result
// register that drives done_o and the result ports, in order, one result per
// accepted color. The receiver cannot stall: done_o and the result ports hold
// for one cycle only.
module nearest_ega_palette_remap_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [7:0] in_red_i,
  input  wire logic [7:0] in_green_i,
  input  wire logic [7:0] in_blue_i,
  output logic            done_o,
  output logic [4:0]      atc_value_o,
  output logic [7:0]      show_red_o,
  output logic [7:0]      show_green_o,
  output logic [7:0]      show_blue_o
);

  nepr_pkg::stage_t chain [0:nepr_pkg::NumRefs];
  nepr_pkg::rgb_t   show;

  // The chain never blocks a new word.
  assign busy_o = 1'b0;

  // Word entering the first cell: best starts at the threshold with reference 0.
  assign chain[0].valid       = start_i;
  assign chain[0].color.red   = in_red_i;
  assign chain[0].color.green = in_green_i;
  assign chain[0].color.blue  = in_blue_i;
  assign chain[0].best_dist   = nepr_pkg::StartBest;
  assign chain[0].best_ref    = '0;

  // One cell per reference color.
  for (genvar k = 0; k < nepr_pkg::NumRefs; k++) begin : g_cell
    nepr_cell #(
      .RefIdx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .stage_i(chain[k]),
      .stage_o(chain[k+1])
    );
  end

  // Attribute and palette lookup, registered onto the result ports.
  nepr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (chain[nepr_pkg::NumRefs]),
    .done_o     (done_o),
    .atc_value_o(atc_value_o),
    .show_o     (show)
  );

  assign show_red_o   = show.red;
  assign show_green_o = show.green;
  assign show_blue_o  = show.blue;

endmodule

`default_nettype wire
